### rtl/lr_pkg.sv
`default_nettype none
package lr_pkg;

  localparam int COORD_BITS  = 6;
  localparam int COLOUR_BITS = 32;

  // err spans [-2*da, 2*db) with da, db < 2^COORD_BITS
  localparam int ERR_W = COORD_BITS + 3;

  localparam int IN_BITS   = 4 * COORD_BITS + COLOUR_BITS;
  localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = 2 * COORD_BITS + COLOUR_BITS;
  localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [COORD_BITS-1:0]         coord_t;
  typedef logic [COLOUR_BITS-1:0]        colour_t;
  typedef logic signed [ERR_W-1:0]       err_t;
  typedef logic [QPTR_W-1:0]             qptr_t;
  typedef logic [QCNT_W-1:0]             qcnt_t;

  localparam qptr_t QPTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
  localparam qcnt_t QCNT_FULL = QCNT_W'(QUEUE_DEPTH);

  // One classified line, major axis always increasing
  typedef struct packed {
    logic    major_is_y;
    logic    step_neg;
    coord_t  a_start;
    coord_t  b_start;
    coord_t  a_end;
    err_t    err_init;
    err_t    inc_straight;
    err_t    inc_diag;
    colour_t colour;
  } lr_desc_t;

  function automatic err_t twice(input coord_t v);
    return {{(ERR_W - COORD_BITS - 1){1'b0}}, v, 1'b0};
  endfunction

  function automatic err_t widen(input coord_t v);
    return {{(ERR_W - COORD_BITS){1'b0}}, v};
  endfunction

endpackage
`default_nettype wire

### rtl/lr_front.sv
`default_nettype none
module lr_front (
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  // x_start, y_start, x_end, y_end, pen_colour (lowest bit up)
  input  wire logic [lr_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                            q_push,
  input  wire logic                       q_ready,
  output lr_pkg::lr_desc_t                desc
);

  lr_pkg::coord_t  x0, y0, x1, y1;
  lr_pkg::coord_t  adx, ady, da, db;
  lr_pkg::coord_t  a0, b0, a1, b1;
  logic            x_major, swap;

  always_comb begin
    x0 = s_tdata[0*lr_pkg::COORD_BITS +: lr_pkg::COORD_BITS];
    y0 = s_tdata[1*lr_pkg::COORD_BITS +: lr_pkg::COORD_BITS];
    x1 = s_tdata[2*lr_pkg::COORD_BITS +: lr_pkg::COORD_BITS];
    y1 = s_tdata[3*lr_pkg::COORD_BITS +: lr_pkg::COORD_BITS];

    adx = (x1 > x0) ? (x1 - x0) : (x0 - x1);
    ady = (y1 > y0) ? (y1 - y0) : (y0 - y1);

    // ties go y-major
    x_major = (ady < adx);
    swap    = x_major ? (x0 > x1) : (y0 > y1);

    if (x_major) begin
      a0 = swap ? x1 : x0;
      b0 = swap ? y1 : y0;
      a1 = swap ? x0 : x1;
      b1 = swap ? y0 : y1;
      da = adx;
      db = ady;
    end else begin
      a0 = swap ? y1 : y0;
      b0 = swap ? x1 : x0;
      a1 = swap ? y0 : y1;
      b1 = swap ? x0 : x1;
      da = ady;
      db = adx;
    end

    desc.major_is_y   = !x_major;
    desc.step_neg     = (b1 < b0);
    desc.a_start      = a0;
    desc.b_start      = b0;
    desc.a_end        = a1;
    desc.err_init     = lr_pkg::twice(db) - lr_pkg::widen(da);
    desc.inc_straight = lr_pkg::twice(db);
    desc.inc_diag     = lr_pkg::twice(db) - lr_pkg::twice(da);
    desc.colour       = s_tdata[4*lr_pkg::COORD_BITS +: lr_pkg::COLOUR_BITS];
  end

  assign s_tready = q_ready;
  assign q_push   = s_tvalid;

endmodule
`default_nettype wire

### rtl/lr_queue.sv
`default_nettype none
module lr_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   push_ready,
  input  wire lr_pkg::lr_desc_t  push_desc,
  output logic                   pop_valid,
  input  wire logic              pop,
  output lr_pkg::lr_desc_t       pop_desc
);

  lr_pkg::lr_desc_t mem [lr_pkg::QUEUE_DEPTH];
  lr_pkg::qptr_t    wr_ptr, rd_ptr;
  lr_pkg::qcnt_t    count;
  logic             do_push, do_pop;

  assign push_ready = (count != lr_pkg::QCNT_FULL);
  assign pop_valid  = (count != '0);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_desc   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == lr_pkg::QPTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == lr_pkg::QPTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/lr_walk.sv
`default_nettype none
module lr_walk (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         q_valid,
  output logic                              q_pop,
  input  wire lr_pkg::lr_desc_t             q_desc,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // pixel_x, pixel_y, pixel_colour (lowest bit up)
  output logic [lr_pkg::M_TDATA_W-1:0]      m_tdata,
  output logic                              m_tlast
);

  logic            busy;
  logic            major_is_y, step_neg;
  lr_pkg::coord_t  a, b, a_end;
  lr_pkg::err_t    err, inc_straight, inc_diag;
  lr_pkg::colour_t colour;

  logic            load, emit, at_end;
  lr_pkg::coord_t  px, py;
  logic [lr_pkg::M_TDATA_W-1:0] m_tdata_next;

  assign load   = !busy && q_valid;
  assign emit   = busy && (!m_tvalid || m_tready);
  assign at_end = (a == a_end);
  assign q_pop  = load;

  always_comb begin
    px = major_is_y ? b : a;
    py = major_is_y ? a : b;
    m_tdata_next = '0;
    m_tdata_next[lr_pkg::OUT_BITS-1:0] = {colour, py, px};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        busy <= 1'b1;
      end else if (emit && at_end) begin
        busy <= 1'b0;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      major_is_y   <= q_desc.major_is_y;
      step_neg     <= q_desc.step_neg;
      a            <= q_desc.a_start;
      b            <= q_desc.b_start;
      a_end        <= q_desc.a_end;
      err          <= q_desc.err_init;
      inc_straight <= q_desc.inc_straight;
      inc_diag     <= q_desc.inc_diag;
      colour       <= q_desc.colour;
    end else if (emit && !at_end) begin
      a <= a + 1'b1;
      if (err[lr_pkg::ERR_W-1]) begin
        err <= err + inc_straight;
      end else begin
        err <= err + inc_diag;
        b   <= step_neg ? (b - 1'b1) : (b + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= m_tdata_next;
      m_tlast <= at_end;
    end
  end

endmodule
`default_nettype wire

### rtl/line_rasterizer.sv
// A command is registered in the queue, then in the walker's line registers;
// each pixel then goes to the output register. Throughput: one pixel per cycle
//   inside a line unless m_tready stalls it; each line first takes a load step.
// A 2-entry command queue lets new commands enter while a line is walked.
// Reset (rst, synchronous, active high) empties the queue and the output.
`default_nettype none
module line_rasterizer (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  // x_start, y_start, x_end, y_end, pen_colour (lowest bit up)
  input  wire logic [lr_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // pixel_x, pixel_y, pixel_colour (lowest bit up)
  output logic [lr_pkg::M_TDATA_W-1:0]      m_tdata,
  output logic                              m_tlast
);

  logic             q_push, q_ready, q_valid, q_pop;
  lr_pkg::lr_desc_t push_desc, pop_desc;

  lr_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_push   (q_push),
    .q_ready  (q_ready),
    .desc     (push_desc)
  );

  lr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_ready (q_ready),
    .push_desc  (push_desc),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_desc   (pop_desc)
  );

  lr_walk u_walk (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_desc   (pop_desc),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire

### rtl/lr_checker.sv
`default_nettype none
module lr_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         s_tvalid,
  input wire logic                         s_tready,
  input wire logic                         m_tvalid,
  input wire logic                         m_tready,
  input wire logic [lr_pkg::M_TDATA_W-1:0] m_tdata,
  input wire logic                         m_tlast
);

  logic            in_beat, out_beat;
  logic            prev_valid, prev_last;
  lr_pkg::coord_t  prev_x, prev_y, cur_x, cur_y, dx, dy;
  lr_pkg::colour_t prev_colour, cur_colour;
  logic [2:0]      pending;
  logic            dx_small, dy_small;

  assign in_beat    = s_tvalid && s_tready;
  assign out_beat   = m_tvalid && m_tready;
  assign cur_x      = m_tdata[0 +: lr_pkg::COORD_BITS];
  assign cur_y      = m_tdata[lr_pkg::COORD_BITS +: lr_pkg::COORD_BITS];
  assign cur_colour = m_tdata[2*lr_pkg::COORD_BITS +: lr_pkg::COLOUR_BITS];
  assign dx         = cur_x - prev_x;
  assign dy         = cur_y - prev_y;
  assign dx_small   = (dx == '0) || (dx == lr_pkg::coord_t'(1)) || (dx == '1);
  assign dy_small   = (dy == '0) || (dy == lr_pkg::coord_t'(1)) || (dy == '1);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_valid <= 1'b0;
      pending    <= '0;
    end else begin
      if (out_beat) begin
        prev_valid <= 1'b1;
      end
      if (in_beat && !(out_beat && m_tlast)) begin
        pending <= pending + 1'b1;
      end else if (!in_beat && out_beat && m_tlast) begin
        pending <= pending - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_beat) begin
      prev_last   <= m_tlast;
      prev_x      <= cur_x;
      prev_y      <= cur_y;
      prev_colour <= cur_colour;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output beat changed");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pending != '0)
    else $error("pixel beat without an open line command");

  a_colour: assert property (@(posedge clk) disable iff (rst)
    out_beat && prev_valid && !prev_last |-> cur_colour == prev_colour)
    else $error("colour changed inside a line");

  a_adjacent: assert property (@(posedge clk) disable iff (rst)
    out_beat && prev_valid && !prev_last |->
      (dx == lr_pkg::coord_t'(1) && dy_small) || (dy == lr_pkg::coord_t'(1) && dx_small))
    else $error("consecutive pixels of a line are not neighbors");

endmodule

bind line_rasterizer lr_checker u_lr_checker (.*);
`default_nettype wire
